/* src/gtopm_pkg.sv */
// shared types, sizes and operation codes for the outer-product tile accumulator
`default_nettype none
package gtopm_pkg;

   localparam int TILE_ROWS   = 4;
   localparam int TILE_COLS   = 16;
   localparam int ACC_COUNT   = TILE_ROWS * TILE_COLS;
   localparam int MAX_EMIT    = 64;
   localparam int EMIT_COUNT  = (ACC_COUNT > MAX_EMIT) ? MAX_EMIT : ACC_COUNT;

   localparam int A_LANES     = 4;
   localparam int B_LANES     = 16;
   localparam int PACK_LANES  = 4;
   localparam int B_PACKS     = 4;

   localparam int DATA_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = 48;
   localparam int PACK_W      = 64;
   localparam int ROW_W       = 2;
   localparam int COL_W       = 4;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic step_accept;   // multiply step taken this cycle
      logic step_pend;     // products registered, add them now
   } gtopm_ctrl_type;

endpackage
`default_nettype wire

/* src/gemm_tile_outer_product_mac.sv */
// top level of the 4x16 outer-product multiply-accumulate tile
`default_nettype none
// holds a 4x16 tile of 48-bit signed Q32.16 accumulators and updates it by
// rank-1 outer products of signed Q8.8 operands. a transaction is taken at a
// clock edge with start high and busy low. load and multiply step
// transactions may follow one another every cycle while busy is low: a
// step registers its 64 products and adds them, saturating, in the cycle
// after; a drain right behind sees that result, but a load right behind
// overwrites its entry and drops that product. a drain raises busy and reads
// through the single read-out mux that walks the lanes; entries appear
// row-major, one per cycle on rsp_valid, with rsp_last on the final one.
// the receiver cannot stall: every result is on the rsp_ ports for exactly
// one cycle. operation code 3 and loads outside the tile are dropped.
module gemm_tile_outer_product_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [gtopm_pkg::OP_W-1:0]          req_operation,
   input  wire logic [gtopm_pkg::ROW_W-1:0]         req_row,
   input  wire logic [gtopm_pkg::COL_W-1:0]         req_col,
   input  wire logic signed [gtopm_pkg::ACC_W-1:0]  req_c_value,
   input  wire logic [gtopm_pkg::PACK_W-1:0]        req_a_pack,
   input  wire logic [gtopm_pkg::PACK_W-1:0]        req_b_pack_0,
   input  wire logic [gtopm_pkg::PACK_W-1:0]        req_b_pack_1,
   input  wire logic [gtopm_pkg::PACK_W-1:0]        req_b_pack_2,
   input  wire logic [gtopm_pkg::PACK_W-1:0]        req_b_pack_3,
   output logic                                     rsp_valid,
   output logic [gtopm_pkg::ROW_W-1:0]              rsp_out_row,
   output logic [gtopm_pkg::COL_W-1:0]              rsp_out_col,
   output logic signed [gtopm_pkg::ACC_W-1:0]       rsp_value,
   output logic                                     rsp_last
);
   import gtopm_pkg::*;

   logic                    accept;
   logic                    load_accept;
   logic                    drain_accept;
   logic                    step_pend_ff;
   gtopm_ctrl_type          ctrl;
   logic [PACK_W-1:0]       b_packs [B_PACKS];
   logic signed [ACC_W-1:0] acc [ACC_COUNT];
   logic signed [ACC_W-1:0] drain_acc [EMIT_COUNT];

   // transaction decode
   assign accept       = start && !busy;
   assign load_accept  = accept && (req_operation == OP_LOAD);
   assign drain_accept = accept && (req_operation == OP_DRAIN);

   assign ctrl.step_accept = accept && (req_operation == OP_STEP);
   assign ctrl.step_pend   = step_pend_ff;

   // products of a step are added in the cycle after the step is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         step_pend_ff <= 1'b0;
      end else begin
         step_pend_ff <= ctrl.step_accept;
      end
   end

   assign b_packs[0] = req_b_pack_0;
   assign b_packs[1] = req_b_pack_1;
   assign b_packs[2] = req_b_pack_2;
   assign b_packs[3] = req_b_pack_3;

   // one lane per tile entry; rows and columns past the operand packs see zero
   for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
      logic signed [DATA_W-1:0] a_value;
      if (r < A_LANES) begin : g_a
         assign a_value = req_a_pack[DATA_W*r +: DATA_W];
      end else begin : g_a_zero
         assign a_value = '0;
      end
      for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
         localparam int PACK_SEL = c / PACK_LANES;
         localparam int LANE_SEL = c % PACK_LANES;
         logic signed [DATA_W-1:0] b_value;
         logic                     load_en;
         if (c < B_LANES) begin : g_b
            assign b_value = b_packs[PACK_SEL][DATA_W*LANE_SEL +: DATA_W];
         end else begin : g_b_zero
            assign b_value = '0;
         end
         // a load addressing an entry outside the tile matches no lane
         assign load_en = load_accept && (int'(req_row) == r) && (int'(req_col) == c);
         gtopm_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .a_value    (a_value),
            .b_value    (b_value),
            .load_en    (load_en),
            .load_value (req_c_value),
            .acc        (acc[r*TILE_COLS + c])
         );
      end
   end

   // the first EMIT_COUNT entries in row-major order are drained; with these sizes that is all 64
   for (genvar k = 0; k < EMIT_COUNT; k++) begin : g_emit
      assign drain_acc[k] = acc[k];
   end

   gtopm_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .drain_start (drain_accept),
      .acc         (drain_acc),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

   // a drain transaction holds off new transactions from the next cycle on
   assert property (@(posedge clock) disable iff (reset)
      drain_accept |=> busy)
      else $error("busy not raised after drain transaction");

   // the final entry goes out once the sequencer has already released busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy still high on final drain entry");

   // every result comes from a cycle in which the drain was running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a running drain");

   // step products are always scheduled for accumulation in the cycle right after the step
   assert property (@(posedge clock) disable iff (reset)
      ctrl.step_accept |=> step_pend_ff)
      else $error("step products not scheduled for accumulation");

   // no step can be taken while a drain runs, so nothing is added under it
   assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !step_pend_ff)
      else $error("accumulation during drain");

endmodule
`default_nettype wire

/* src/gtopm_lane.sv */
// one accumulator lane: registered multiply, saturating add, preset by load
`default_nettype none
module gtopm_lane (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gtopm_pkg::gtopm_ctrl_type          ctrl,
   input  wire logic signed [gtopm_pkg::DATA_W-1:0] a_value,
   input  wire logic signed [gtopm_pkg::DATA_W-1:0] b_value,
   input  wire logic                               load_en,
   input  wire logic signed [gtopm_pkg::ACC_W-1:0] load_value,
   output logic signed [gtopm_pkg::ACC_W-1:0]      acc
);
   import gtopm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W:0]    sum;

   // product stage
   always_ff @(posedge clock) begin
      if (ctrl.step_accept) begin
         prod_ff <= a_value * b_value;
      end
   end

   assign sum = {acc_ff[ACC_W-1], acc_ff} + {{(ACC_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (load_en) begin
         acc_in = load_value;
      end else if (ctrl.step_pend) begin
         if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_in = sum[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

/* src/gtopm_drain.sv */
// drain sequencer: walks the tile row-major and registers one entry per cycle
`default_nettype none
module gtopm_drain (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                drain_start,
   input  wire logic signed [gtopm_pkg::ACC_W-1:0]  acc [gtopm_pkg::EMIT_COUNT],
   output logic                                     busy,
   output logic                                     rsp_valid,
   output logic [gtopm_pkg::ROW_W-1:0]              rsp_out_row,
   output logic [gtopm_pkg::COL_W-1:0]              rsp_out_col,
   output logic signed [gtopm_pkg::ACC_W-1:0]       rsp_value,
   output logic                                     rsp_last
);
   import gtopm_pkg::*;

   localparam int IDX_W  = (EMIT_COUNT > 1) ? $clog2(EMIT_COUNT) : 1;
   localparam int RCNT_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
   localparam int CCNT_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
   localparam logic [IDX_W-1:0]  IDX_END = IDX_W'(EMIT_COUNT - 1);
   localparam logic [CCNT_W-1:0] COL_END = CCNT_W'(TILE_COLS - 1);

   logic              active_ff;
   logic              valid_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [RCNT_W-1:0] row_ff;
   logic [CCNT_W-1:0] col_ff;
   logic              at_end;

   logic [ROW_W-1:0]        out_row_ff;
   logic [COL_W-1:0]        out_col_ff;
   logic signed [ACC_W-1:0] value_ff;
   logic                    last_ff;

   assign at_end = (idx_ff == IDX_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         idx_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         valid_ff <= active_ff;
         if (drain_start) begin
            active_ff <= 1'b1;
            idx_ff    <= '0;
            row_ff    <= '0;
            col_ff    <= '0;
         end else if (active_ff) begin
            if (at_end) begin
               active_ff <= 1'b0;
            end
            idx_ff <= idx_ff + IDX_W'(1);
            if (col_ff == COL_END) begin
               col_ff <= '0;
               row_ff <= row_ff + RCNT_W'(1);
            end else begin
               col_ff <= col_ff + CCNT_W'(1);
            end
         end
      end
   end

   // merge: pick the addressed lane into the result register
   always_ff @(posedge clock) begin
      if (active_ff) begin
         out_row_ff <= ROW_W'(row_ff);
         out_col_ff <= COL_W'(col_ff);
         value_ff   <= acc[idx_ff];
         last_ff    <= at_end;
      end
   end

   assign busy        = active_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_value   = value_ff;
   assign rsp_last    = last_ff;

endmodule
`default_nettype wire
